@@ hw/rtl/tgslm_pkg.sv @@
// ----------------------------------------------------------------------------
// tgslm_pkg: shared types and constants of the two-gate speed and length meter
// Edge event and result payloads, register indexes, reset values, datapath
// widths and the divider status group.
// ----------------------------------------------------------------------------
package tgslm_pkg;

  localparam int TIME_W   = 32;  // millisecond timestamps and durations
  localparam int CFG_W    = 16;  // every configuration register
  localparam int CFG_IDX_W = 2;
  localparam int NUM_W    = 48;  // numerator (distance times 1000 or mean)
  localparam int DEN_W    = 32;  // magnitude of dt
  localparam int OUT_W    = 48;  // signed fixed-point result fields

  localparam int SPEED_SCALE = 1000;  // ms to s

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE  = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd10;
  localparam logic [CFG_W-1:0] TOLERANCE_RST = 16'd100;
  localparam logic [CFG_W-1:0] DISTANCE_RST  = 16'd10;

  // Saturation bounds of a result magnitude
  localparam logic [OUT_W-1:0] LIM_POS = 48'h7FFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] LIM_NEG = 48'h8000_0000_0000;

  typedef struct packed {
    logic              channel;
    logic              level;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] speed_q16;
    logic signed [OUT_W-1:0] length_q16;
    logic                    divide_error;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hw/rtl/two_gate_speed_length_meter.sv @@
// ----------------------------------------------------------------------------
// two_gate_speed_length_meter: speed and length from two occupancy gates
// Edge without a result: in_stall high through S_EVAL (and S_MATCH on a miss).
// Edge with a result: S_EVAL, S_MATCH, S_MUL, the one bit-serial divider run
// twice (speed, then length), S_DONE, then out_valid; zero dt skips to S_DONE.
// One edge at a time: in_stall stays high from transfer until the work is done.
// Synchronous active-low reset restores registers 10/100/10 and clears state.
// ----------------------------------------------------------------------------
module two_gate_speed_length_meter #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tgslm_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tgslm_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [tgslm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tgslm_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int TIME_W = tgslm_pkg::TIME_W;
  localparam int CFG_W  = tgslm_pkg::CFG_W;
  localparam int NUM_W  = tgslm_pkg::NUM_W;
  localparam int DEN_W  = tgslm_pkg::DEN_W;
  localparam int OUT_W  = tgslm_pkg::OUT_W;
  localparam int QUO_W  = NUM_W + FRACTION_BITS;
  localparam int SPN_W  = CFG_W + 10;  // distance times 1000

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MATCH,
    S_MUL,
    S_DIV_SP,
    S_DIV_LN,
    S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [CFG_W-1:0] debounce_r;
  logic [CFG_W-1:0] tolerance_r;
  logic [CFG_W-1:0] distance_r;

  // per-gate state
  logic              prev_level_r  [2];
  logic [TIME_W-1:0] last_accept_r [2];
  logic [TIME_W-1:0] front_r       [2];
  logic [TIME_W-1:0] occupied_r    [2];
  logic              last_rising_r;

  // current item and working values
  tgslm_pkg::in_item_t item_r;
  logic              neg_r;
  logic [DEN_W-1:0]  mag_dt_r;
  logic [TIME_W-1:0] mean_r;
  logic [NUM_W-1:0]  num_sp_r;
  logic [NUM_W-1:0]  num_ln_r;
  logic [OUT_W-1:0]  speed_r;
  logic [OUT_W-1:0]  length_r;
  logic              err_r;
  logic              div_start_r;

  logic                 out_valid_r;
  tgslm_pkg::out_item_t out_data_r;

  // evaluation of the accepted edge
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] dur_new;
  logic              bounced;
  logic              fall_edge;
  logic              rise_edge;

  assign elapsed   = item_r.now_ms - last_accept_r[item_r.channel];
  assign dur_new   = item_r.now_ms - front_r[item_r.channel];
  assign bounced   = elapsed <= TIME_W'(debounce_r);
  assign fall_edge = prev_level_r[item_r.channel] && !item_r.level;
  assign rise_edge = !prev_level_r[item_r.channel] && item_r.level;

  // duration match and dt
  logic [TIME_W-1:0] dur_diff;
  logic              matched;
  logic [TIME_W-1:0] dt_raw;
  logic [TIME_W:0]   dur_sum;

  assign dur_diff = (occupied_r[1] > occupied_r[0]) ? occupied_r[1] - occupied_r[0]
                                                    : occupied_r[0] - occupied_r[1];
  assign matched  = dur_diff <= TIME_W'(tolerance_r);
  assign dt_raw   = front_r[1] - front_r[0];
  assign dur_sum  = {1'b0, occupied_r[0]} + {1'b0, occupied_r[1]};

  // shared divider
  logic [NUM_W-1:0]     div_num;
  logic [QUO_W-1:0]     div_quo;
  tgslm_pkg::div_stat_t div_stat;

  assign div_num = (state_r == S_DIV_LN) ? num_ln_r : num_sp_r;

  tgslm_div #(
    .FRAC_W (FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num),
    .den   (mag_dt_r),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // saturate the magnitude, then apply the sign of dt
  logic [QUO_W-1:0] lim;
  logic [QUO_W-1:0] quo_sat;
  logic [OUT_W-1:0] quo_signed;

  assign lim        = neg_r ? QUO_W'(tgslm_pkg::LIM_NEG) : QUO_W'(tgslm_pkg::LIM_POS);
  assign quo_sat    = (div_quo > lim) ? lim : div_quo;
  assign quo_signed = neg_r ? (OUT_W'(0) - quo_sat[OUT_W-1:0]) : quo_sat[OUT_W-1:0];

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      debounce_r    <= tgslm_pkg::DEBOUNCE_RST;
      tolerance_r   <= tgslm_pkg::TOLERANCE_RST;
      distance_r    <= tgslm_pkg::DISTANCE_RST;
      for (int i = 0; i < 2; i++) begin
        prev_level_r[i]  <= 1'b0;
        last_accept_r[i] <= '0;
        front_r[i]       <= '0;
        occupied_r[i]    <= '0;
      end
      last_rising_r <= 1'b0;
      div_start_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      // in S_DONE the output register is reloaded below instead
      if (out_xfer && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          tgslm_pkg::CFG_DEBOUNCE:  debounce_r  <= cfg_wdata;
          tgslm_pkg::CFG_TOLERANCE: tolerance_r <= cfg_wdata;
          tgslm_pkg::CFG_DISTANCE:  distance_r  <= cfg_wdata;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            item_r  <= in_data;
            state_r <= S_EVAL;
          end
        end

        S_EVAL: begin
          state_r <= S_IDLE;
          if (!bounced) begin
            last_accept_r[item_r.channel] <= item_r.now_ms;
            prev_level_r[item_r.channel]  <= item_r.level;
            if (fall_edge) begin
              front_r[item_r.channel] <= item_r.now_ms;
            end else if (rise_edge) begin
              occupied_r[item_r.channel] <= dur_new;
              last_rising_r              <= item_r.channel;
              if (last_rising_r != item_r.channel) begin
                state_r <= S_MATCH;
              end
            end
          end
        end

        S_MATCH: begin
          neg_r    <= dt_raw[TIME_W-1];
          mag_dt_r <= dt_raw[TIME_W-1] ? (TIME_W'(0) - dt_raw) : dt_raw;
          mean_r   <= dur_sum[TIME_W:1];
          if (!matched) begin
            state_r <= S_IDLE;
          end else if (dt_raw == '0) begin
            speed_r  <= '0;
            length_r <= '0;
            err_r    <= 1'b1;
            state_r  <= S_DONE;
          end else begin
            err_r    <= 1'b0;
            state_r  <= S_MUL;
          end
        end

        S_MUL: begin
          num_sp_r    <= NUM_W'(SPN_W'(distance_r) * SPN_W'(tgslm_pkg::SPEED_SCALE));
          num_ln_r    <= NUM_W'(distance_r) * NUM_W'(mean_r);
          div_start_r <= 1'b1;
          state_r     <= S_DIV_SP;
        end

        S_DIV_SP: begin
          if (div_stat.done) begin
            speed_r     <= quo_signed;
            div_start_r <= 1'b1;
            state_r     <= S_DIV_LN;
          end
        end

        S_DIV_LN: begin
          if (div_stat.done) begin
            length_r <= quo_signed;
            state_r  <= S_DONE;
          end
        end

        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_data_r.speed_q16    <= speed_r;
            out_data_r.length_q16   <= length_r;
            out_data_r.divide_error <= err_r;
            out_valid_r             <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_in_goes_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_EVAL)
    else $error("input transfer did not start evaluation");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV_SP || state_r == S_DIV_LN))
    else $error("divider finished outside a divide state");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.divide_error) |->
      (out_data_r.speed_q16 == '0 && out_data_r.length_q16 == '0))
    else $error("divide error result carries nonzero values");

endmodule

@@ hw/rtl/tgslm_div.sv @@
// ----------------------------------------------------------------------------
// tgslm_div: bit-serial restoring divider
// Divides num * 2^FRAC_W by den, one quotient bit per cycle. The quotient
// shifts in behind the dividend bits in the same register.
// ----------------------------------------------------------------------------
module tgslm_div #(
  parameter int FRAC_W = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [tgslm_pkg::NUM_W-1:0]          num,
  input  logic [tgslm_pkg::DEN_W-1:0]          den,
  output logic [tgslm_pkg::NUM_W+FRAC_W-1:0]   quo,
  output tgslm_pkg::div_stat_t                 stat
);

  localparam int DVD_W = tgslm_pkg::NUM_W + FRAC_W;
  localparam int DEN_W = tgslm_pkg::DEN_W;
  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DVD_W-1:0] dvd_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             fits;

  assign trial     = {rem_r, dvd_r[DVD_W-1]};
  assign fits      = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        rem_r <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        dvd_r <= {dvd_r[DVD_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        den_r  <= den;
        dvd_r  <= DVD_W'(num) << FRAC_W;
      end
    end
  end

  assign quo       = dvd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: two-gate speed and length meter
// Sends gate edge events through the valid/stall input channel and predicts
// every speed/length result from a behavioral model of the meter. Each result
// transfer is compared field by field with the oldest prediction, over several
// register settings and sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FRAC            = 16;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int SETTLE_CYCLES   = 8;
  localparam int MAX_REPORTS     = 100;

  localparam int TIME_W      = tgslm_pkg::TIME_W;
  localparam int CFG_W       = tgslm_pkg::CFG_W;
  localparam int CFG_IDX_W   = tgslm_pkg::CFG_IDX_W;
  localparam int OUT_W       = tgslm_pkg::OUT_W;
  localparam int SPEED_SCALE = tgslm_pkg::SPEED_SCALE;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  tgslm_pkg::in_item_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  tgslm_pkg::out_item_t out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int idle_pct      = 0;
  int stall_pct     = 0;
  int fail_count    = 0;
  int edges_counted = 0;

  // meter state as the predictor sees it
  logic [CFG_W-1:0]  debounce_cfg, tolerance_cfg, distance_cfg;
  logic              gate_level   [2];
  logic [TIME_W-1:0] last_edge_ms [2];
  logic [TIME_W-1:0] front_time   [2];
  logic [TIME_W-1:0] occupancy    [2];
  logic              last_rise_ch;

  tgslm_pkg::out_item_t pending_results [$];

  two_gate_speed_length_meter #(
    .FRACTION_BITS(FRAC)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // |num| * 2^FRAC / den, truncated and saturated to the signed 48-bit range
  function automatic logic [OUT_W-1:0] fixed_quotient(logic [63:0] num,
                                                      logic [TIME_W-1:0] den,
                                                      logic neg);
    logic [95:0] scaled;
    logic [95:0] limit;
    limit  = neg ? {48'd0, tgslm_pkg::LIM_NEG} : {48'd0, tgslm_pkg::LIM_POS};
    scaled = ({32'd0, num} << FRAC) / {64'd0, den};
    if (scaled > limit) return limit[OUT_W-1:0];
    return scaled[OUT_W-1:0];
  endfunction

  task automatic predict_edge(tgslm_pkg::in_item_t e);
    logic [TIME_W-1:0]    since, d_diff, dt_raw, dt_mag, mean;
    logic [TIME_W:0]      d_sum;
    logic                 neg;
    logic [OUT_W-1:0]     speed_mag, length_mag;
    tgslm_pkg::out_item_t res;
    logic                 ch;
    ch    = e.channel;
    since = e.now_ms - last_edge_ms[ch];
    if (since <= {16'd0, debounce_cfg}) return;
    edges_counted++;
    if (gate_level[ch] && !e.level) begin
      front_time[ch] = e.now_ms;
    end else if (!gate_level[ch] && e.level) begin
      occupancy[ch] = e.now_ms - front_time[ch];
      if (last_rise_ch != e.channel) begin
        d_diff = (occupancy[1] > occupancy[0]) ? occupancy[1] - occupancy[0]
                                               : occupancy[0] - occupancy[1];
        if (d_diff <= {16'd0, tolerance_cfg}) begin
          dt_raw = front_time[1] - front_time[0];
          neg    = dt_raw[TIME_W-1];
          dt_mag = neg ? -dt_raw : dt_raw;
          res    = '0;
          if (dt_mag == '0) begin
            res.divide_error = 1'b1;
          end else begin
            d_sum      = {1'b0, occupancy[0]} + {1'b0, occupancy[1]};
            mean       = d_sum[TIME_W:1];
            speed_mag  = fixed_quotient(64'(distance_cfg) * 64'(SPEED_SCALE), dt_mag, neg);
            length_mag = fixed_quotient(64'(distance_cfg) * 64'(mean), dt_mag, neg);
            res.speed_q16  = neg ? (~speed_mag + 48'd1) : speed_mag;
            res.length_q16 = neg ? (~length_mag + 48'd1) : length_mag;
          end
          pending_results.push_back(res);
        end
      end
      last_rise_ch = e.channel;
    end
    last_edge_ms[ch] = e.now_ms;
    gate_level[ch]   = e.level;
  endtask

  task automatic send_edge(logic ch, logic lvl, logic [TIME_W-1:0] stamp);
    tgslm_pkg::in_item_t e;
    e.channel = ch;
    e.level   = lvl;
    e.now_ms  = stamp;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_edge(e);
  endtask

  task automatic report_mismatch(string field_name, longint want, longint got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field_name, want, got);
  endtask

  task automatic check_result(tgslm_pkg::out_item_t got);
    tgslm_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: result with none expected: expected nothing, actual %0d %0d %0b",
                 $time, got.speed_q16, got.length_q16, got.divide_error);
      return;
    end
    want = pending_results.pop_front();
    if (got.speed_q16 !== want.speed_q16)
      report_mismatch("speed_q16", want.speed_q16, got.speed_q16);
    if (got.length_q16 !== want.length_q16)
      report_mismatch("length_q16", want.length_q16, got.length_q16);
    if (got.divide_error !== want.divide_error)
      report_mismatch("divide_error", want.divide_error, got.divide_error);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        idle_pct  = 85;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        idle_pct  = 0;
        stall_pct = 85;
      end
      default: begin
        idle_pct  = 10;
        stall_pct = 10;
      end
    endcase
  endtask

  // Drop valid and let the meter finish before touching its registers
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] tol,
                                logic [CFG_W-1:0] dist_cm);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= tgslm_pkg::CFG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    debounce_cfg = deb;
    cfg_index <= tgslm_pkg::CFG_TOLERANCE;
    cfg_wdata <= tol;
    @(posedge clk);
    tolerance_cfg = tol;
    cfg_index <= tgslm_pkg::CFG_DISTANCE;
    cfg_wdata <= dist_cm;
    @(posedge clk);
    distance_cfg = dist_cm;
    cfg_we <= 1'b0;
  endtask

  // One object passing both gates: two falling fronts, two rising ends
  task automatic send_passage();
    logic [TIME_W-1:0] base, dt_mag, dur_a, dur_b, delta, wait_ms;
    logic [63:0]       key [4];
    logic [63:0]       swap;
    logic              first;
    int                pick;
    wait_ms = 32'(debounce_cfg) + 32'd1;
    base    = last_edge_ms[0] + wait_ms + $urandom_range(0, 50);
    if (base - last_edge_ms[1] < wait_ms)
      base = last_edge_ms[1] + wait_ms + $urandom_range(0, 50);
    // raise any gate that is still low so its falling front counts
    for (int ch = 0; ch < 2; ch++)
      if (!gate_level[ch]) send_edge(1'(ch), 1'b1, base);
    base = base + wait_ms + $urandom_range(0, 50);

    pick = $urandom_range(99);
    if (pick < 5) dt_mag = '0;
    else if (pick < 65) dt_mag = $urandom_range(1, 200);
    else if (pick < 90) dt_mag = $urandom_range(1, 100000);
    else dt_mag = $urandom_range(1, 32'h8000_0000);
    dur_a = wait_ms + (($urandom_range(99) < 85) ? $urandom_range(0, 3000)
                                                 : $urandom_range(0, 32'h7FFF_FFFF));
    pick = $urandom_range(99);
    if (pick < 15) delta = '0;
    else if (pick < 30) delta = 32'(tolerance_cfg);
    else if (pick < 70) delta = $urandom_range(0, tolerance_cfg);
    else delta = 32'(tolerance_cfg) + $urandom_range(1, 500);
    if ($urandom_range(1) && delta <= dur_a && dur_a - delta >= wait_ms)
      dur_b = dur_a - delta;
    else
      dur_b = dur_a + delta;

    first  = 1'($urandom_range(1));
    key[0] = {29'd0, 33'd0, first, 1'b0};
    key[1] = {29'd0, 33'(dt_mag), !first, 1'b0};
    key[2] = {29'd0, 33'(dur_a), first, 1'b1};
    key[3] = {29'd0, 33'(dt_mag) + 33'(dur_b), !first, 1'b1};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3 - i; j++)
        if (key[j] > key[j+1]) begin
          swap     = key[j];
          key[j]   = key[j+1];
          key[j+1] = swap;
        end
    // now and then drop an edge to break the sequence
    for (int i = 0; i < 4; i++)
      if ($urandom_range(99) >= 5) send_edge(key[i][1], key[i][0], base + key[i][33:2]);
  endtask

  task automatic send_noise();
    logic              ch, lvl;
    logic [TIME_W-1:0] stamp;
    ch  = 1'($urandom_range(1));
    lvl = 1'($urandom_range(1));
    if ($urandom_range(99) < 30) stamp = $urandom;
    else stamp = last_edge_ms[ch] + $urandom_range(0, 2 * debounce_cfg + 4);
    send_edge(ch, lvl, stamp);
  endtask

  task automatic test_debounce_and_zero_dt();
    set_idle(IDLE_NONE);
    send_edge(1'b0, 1'b1, 32'd0);      // within debounce of the reset time
    send_edge(1'b0, 1'b1, 32'd100);    // rising on the same channel as before
    send_edge(1'b1, 1'b1, 32'd100);    // both fronts at zero: dt is zero
    send_edge(1'b0, 1'b0, 32'd110);    // exactly the debounce time: dropped
    send_edge(1'b0, 1'b1, 32'd200);    // level unchanged
  endtask

  task automatic test_matching_rules();
    send_edge(1'b0, 1'b0, 32'd300);
    send_edge(1'b1, 1'b0, 32'd350);
    send_edge(1'b0, 1'b1, 32'd500);    // difference equals the tolerance
    send_edge(1'b1, 1'b1, 32'd560);
    send_edge(1'b0, 1'b0, 32'd700);
    send_edge(1'b0, 1'b1, 32'd800);    // durations too far apart
    send_edge(1'b0, 1'b0, 32'd900);
    send_edge(1'b0, 1'b1, 32'd1000);   // same rising channel twice
    send_edge(1'b1, 1'b0, 32'd2000);
    send_edge(1'b0, 1'b0, 32'd2100);
    send_edge(1'b1, 1'b1, 32'd2300);
    send_edge(1'b0, 1'b1, 32'd2310);   // gate 1 first: negative dt
  endtask

  task automatic test_sign_and_saturation();
    send_edge(1'b0, 1'b0, 32'd3000);
    send_edge(1'b1, 1'b0, 32'd3001);
    send_edge(1'b0, 1'b1, 32'd3000 + 32'h8000_0000);
    send_edge(1'b1, 1'b1, 32'd3001 + 32'h8000_0000);
    send_edge(1'b1, 1'b0, 32'h8000_1000);
    send_edge(1'b0, 1'b0, 32'h8000_1001);
    send_edge(1'b1, 1'b1, 32'hFFFF_FFFF);
    send_edge(1'b0, 1'b1, 32'h0000_0000);
  endtask

  task automatic test_random_traffic(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] tol,
                                     logic [CFG_W-1:0] dist_cm, idle_mode_t mode);
    int goal;
    apply_settings(deb, tol, dist_cm);
    set_idle(mode);
    goal = edges_counted + ITEMS_PER_PHASE;
    while (edges_counted < goal) begin
      if ($urandom_range(99) < 75) send_passage();
      else repeat ($urandom_range(1, 4)) send_noise();
    end
  endtask

  initial begin
    debounce_cfg  = tgslm_pkg::DEBOUNCE_RST;
    tolerance_cfg = tgslm_pkg::TOLERANCE_RST;
    distance_cfg  = tgslm_pkg::DISTANCE_RST;
    for (int i = 0; i < 2; i++) begin
      gate_level[i]   = 1'b0;
      last_edge_ms[i] = '0;
      front_time[i]   = '0;
      occupancy[i]    = '0;
    end
    last_rise_ch = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_debounce_and_zero_dt();
    test_matching_rules();
    test_sign_and_saturation();

    test_random_traffic(tgslm_pkg::DEBOUNCE_RST, tgslm_pkg::TOLERANCE_RST,
                        tgslm_pkg::DISTANCE_RST, IDLE_NONE);
    test_random_traffic(16'd0, 16'd0, 16'd1, IDLE_SENDER);
    test_random_traffic(16'hFFFF, 16'hFFFF, 16'hFFFF, IDLE_RECEIVER);
    test_random_traffic(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(1, 65535)), IDLE_BOTH);
    test_random_traffic(16'd0, 16'hFFFF, 16'hFFFF, IDLE_NONE);
    test_random_traffic(16'hFFFF, 16'd0, 16'd1, IDLE_SENDER);
    test_random_traffic(16'($urandom_range(0, 50)), 16'($urandom_range(0, 300)),
                        16'($urandom_range(1, 500)), IDLE_RECEIVER);
    test_random_traffic(tgslm_pkg::DEBOUNCE_RST, tgslm_pkg::TOLERANCE_RST,
                        tgslm_pkg::DISTANCE_RST, IDLE_BOTH);

    drain_results();
    repeat (200) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0t: results still expected: expected 0, actual %0d",
               $time, pending_results.size());
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
